// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// S-box tables, GF(2^8) helpers and round transforms used by the core.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int ROUNDS      = 10;
   localparam int NUM_KEYS    = ROUNDS + 1;
   localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
   localparam int BLOCK_W     = 128;
   localparam int HALF_W      = 64;
   localparam int CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b1;
   localparam logic [7:0] GF_HIGH_BIT = 8'h80;
   localparam logic [7:0] GF_REDUCE   = 8'h1B;
   localparam logic [7:0] RCON_FIRST  = 8'h01;

   typedef logic [BLOCK_W-1:0] block_type;

   typedef struct packed {
      logic      valid;
      logic      decrypt;
      block_type data;
   } stage_type;

   localparam logic [2047:0] FWD_SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return FWD_SBOX[2047 - 8*b -: 8];
   endfunction

   function automatic logic [7:0] rev_sbox(input logic [7:0] b);
      return INV_SBOX[2047 - 8*b -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (((b & GF_HIGH_BIT) != 8'h00) ? GF_REDUCE : 8'h00);
   endfunction

   // Byte i of a block sits at bits 127-8i downward.
   function automatic logic [7:0] get_byte(input block_type s, input int i);
      return s[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s, input logic inv);
      block_type t;
      int        from;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            from = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
            t[BLOCK_W-1-8*(4*c+r) -: 8] = inv ? rev_sbox(get_byte(s, 4*from + r))
                                              : sbox(get_byte(s, 4*from + r));
         end
      end
      return t;
   endfunction

   function automatic block_type mix(input block_type s, input logic inv);
      block_type   t;
      logic [7:0]  a [4];
      logic [7:0]  x2 [4];
      logic [7:0]  x4 [4];
      logic [7:0]  x8 [4];
      logic [7:0]  m2, m3, m9, m11, m13, m14;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j]  = get_byte(s, 4*c + j);
            x2[j] = xtime(a[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
         end
         for (int r = 0; r < 4; r++) begin
            m2  = x2[r];
            m3  = x2[(r+1)&3] ^ a[(r+1)&3];
            m14 = x8[r] ^ x4[r] ^ x2[r];
            m11 = x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3];
            m13 = x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3];
            m9  = x8[(r+3)&3] ^ a[(r+3)&3];
            t[BLOCK_W-1-8*(4*c+r) -: 8] = inv ? (m14 ^ m11 ^ m13 ^ m9)
                                              : (m2 ^ m3 ^ a[(r+2)&3] ^ a[(r+3)&3]);
         end
      end
      return t;
   endfunction

   // One key expansion step: round key r from round key r-1.
   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w [4];
      logic [31:0] t;
      block_type   o;
      for (int i = 0; i < 4; i++) w[i] = k[BLOCK_W-1-32*i -: 32];
      t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
      w[0] = w[0] ^ t;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      for (int i = 0; i < 4; i++) o[BLOCK_W-1-32*i -: 32] = w[i];
      return o;
   endfunction

endpackage

// ===== rtl/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the key into eleven round keys held in flip-flops, one per cycle.
// ----------------------------------------------------------------------------
module aes_key_sched (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  aes_pkg::block_type                      key,
   output aes_pkg::block_type [aes_pkg::ROUNDS:0]  expanded_keys,
   output logic                                    busy
);

   aes_pkg::block_type [aes_pkg::ROUNDS:0] rk_ff;
   logic [aes_pkg::KEY_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]                    rc_ff, rc_in;
   logic                          busy_ff, busy_in;

   always_comb begin
      idx_in  = idx_ff;
      rc_in   = rc_ff;
      busy_in = busy_ff;
      if (start) begin
         idx_in  = aes_pkg::KEY_IDX_W'(1);
         rc_in   = aes_pkg::RCON_FIRST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rc_in = aes_pkg::xtime(rc_ff);
         if (idx_ff == aes_pkg::KEY_IDX_W'(aes_pkg::ROUNDS)) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + aes_pkg::KEY_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= aes_pkg::KEY_IDX_W'(1);
         rc_ff   <= aes_pkg::RCON_FIRST;
         busy_ff <= 1'b1;
      end else begin
         idx_ff  <= idx_in;
         rc_ff   <= rc_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start || reset) begin
         rk_ff[0] <= reset ? '0 : key;
      end else if (busy_ff) begin
         rk_ff[idx_ff] <= aes_pkg::next_key(rk_ff[idx_ff - aes_pkg::KEY_IDX_W'(1)], rc_ff);
      end
   end

   assign expanded_keys = rk_ff;
   assign busy          = busy_ff;

endmodule

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One registered round, encrypt or decrypt chosen per word.
// ----------------------------------------------------------------------------
module aes_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               last,
   input  aes_pkg::block_type enc_key,
   input  aes_pkg::block_type dec_key,
   input  aes_pkg::stage_type stage_in,
   output aes_pkg::stage_type stage_out
);

   aes_pkg::stage_type st_ff, st_in;
   aes_pkg::block_type ss, ak;

   // Encrypt: SB,SR,MC,ARK (no MC in the last). Decrypt: ISR,ISB,ARK,IMC (no IMC in the last).
   always_comb begin
      ss = aes_pkg::sub_shift(stage_in.data, stage_in.decrypt);
      ak = ss ^ dec_key;
      if (stage_in.decrypt) begin
         st_in.data = last ? ak : aes_pkg::mix(ak, 1'b1);
      end else begin
         st_in.data = (last ? ss : aes_pkg::mix(ss, 1'b0)) ^ enc_key;
      end
      st_in.valid   = stage_in.valid;
      st_in.decrypt = stage_in.decrypt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (advance) begin
         st_ff.valid <= st_in.valid;
      end
      if (advance) begin
         st_ff.data    <= st_in.data;
         st_ff.decrypt <= st_in.decrypt;
      end
   end

   assign stage_out = st_ff;

endmodule

// ===== rtl/aes128_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// Fully unrolled ECB encrypt/decrypt pipeline with on-chip key expansion.
// ----------------------------------------------------------------------------
// Pipeline: a request word passes one input key-add stage plus ten round
// stages. Throughput: one word per cycle unless the response is held back
// or a key expansion runs; each round has its own registered stage.
// Reset: clears the key registers and valid bits, then the key schedule
// expands the all-zero key, during which no request is accepted.
// A key write restarts that expansion.
module aes128_block_cipher_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // operation, block_in_high, block_in_low, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // block_out_high, block_out_low
   input  logic         csr_we,
   input  logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [aes_pkg::HALF_W-1:0]    csr_wdata
);

   logic [aes_pkg::HALF_W-1:0] key_high_ff, key_low_ff;
   logic [aes_pkg::HALF_W-1:0] key_high_in, key_low_in;
   aes_pkg::block_type [aes_pkg::ROUNDS:0] rks;
   logic                sched_busy;
   logic                advance;
   aes_pkg::stage_type  stages [aes_pkg::ROUNDS+1];
   aes_pkg::stage_type  in0_ff, in0_in;
   aes_pkg::block_type  blk;

   // The schedule starts from the key as it is after this write, so it sees
   // the new half on the same edge that stores it.
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_we) begin
         case (csr_index)
            aes_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            aes_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   aes_key_sched u_sched (
      .clock         (clock),
      .reset         (reset),
      .start         (csr_we),
      .key           ({key_high_in, key_low_in}),
      .expanded_keys (rks),
      .busy          (sched_busy)
   );

   // The whole pipe moves together unless the output word is held back.
   assign advance    = !stages[aes_pkg::ROUNDS].valid || rsp_tready;
   assign req_tready = advance && !sched_busy && !csr_we;

   // The high half carries block byte 0 in its top bits, so it forms the top
   // of the internal block.
   assign blk = {req_tdata[64:1], req_tdata[128:65]};

   always_comb begin
      in0_in.valid   = req_tvalid && req_tready;
      in0_in.decrypt = req_tdata[0];
      in0_in.data    = blk ^ (req_tdata[0] ? rks[aes_pkg::ROUNDS] : rks[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in0_ff.valid <= 1'b0;
      end else if (advance) begin
         in0_ff.valid <= in0_in.valid;
      end
      if (advance) begin
         in0_ff.data    <= in0_in.data;
         in0_ff.decrypt <= in0_in.decrypt;
      end
   end

   assign stages[0] = in0_ff;

   for (genvar r = 1; r <= aes_pkg::ROUNDS; r++) begin : g_round
      aes_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .last      (r == aes_pkg::ROUNDS),
         .enc_key   (rks[r]),
         .dec_key   (rks[aes_pkg::ROUNDS - r]),
         .stage_in  (stages[r-1]),
         .stage_out (stages[r])
      );
   end

   assign rsp_tvalid = stages[aes_pkg::ROUNDS].valid;
   assign rsp_tdata  = {stages[aes_pkg::ROUNDS].data[63:0],
                        stages[aes_pkg::ROUNDS].data[127:64]};

endmodule
